@@ rtl/core/pbvb_pkg.sv @@
// Package for the page buffer vertical bar writer.
// Holds shared constants and the decoded bar command type; no dependencies.
`default_nettype none

package pbvb_pkg;

    // Default framebuffer geometry
    localparam int PAGE_COUNT_DEF   = 8;
    localparam int COLUMN_COUNT_DEF = 128;

    // Fixed drawing limits
    localparam int PAGE_HEIGHT   = 8;
    localparam int MAX_THICKNESS = 8;
    localparam int MAX_WRITES    = 64;
    localparam int WCNT_W        = $clog2(MAX_WRITES);

    // Bar decoded by the front end, one per queue entry
    typedef struct packed {
        logic [6:0] left_column;
        logic [2:0] first_page;
        logic [2:0] first_bit;
        logic [4:0] end_page;
        logic [2:0] end_bit;
        logic       has_above;
        logic [4:0] bar_count;
        logic [4:0] per_col;
        logic [3:0] col_count;
    } bar_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/pbvb_channel_if.sv @@
// Handshake channels for the bar writer: bar input and byte-write output.
// Plain valid/ready interfaces; no dependencies.
`default_nettype none

interface pbvb_bar_if;
    logic       valid;
    logic       ready;
    logic [6:0] left_column;
    logic [5:0] top_row;
    logic [6:0] bar_length;
    logic [3:0] bar_thickness;

    modport source (output valid, left_column, top_row, bar_length, bar_thickness,
                    input ready);
    modport sink   (input valid, left_column, top_row, bar_length, bar_thickness,
                    output ready);
endinterface

interface pbvb_write_if;
    logic       valid;
    logic       ready;
    logic [2:0] page_index;
    logic [6:0] column_index;
    logic [7:0] pixel_byte;
    logic       last_write;

    modport source (output valid, page_index, column_index, pixel_byte, last_write,
                    input ready);
    modport sink   (input valid, page_index, column_index, pixel_byte, last_write,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/page_buffer_vertical_bar_draw.sv @@
// Vertical bar writer for a page-organized monochrome framebuffer.
// Channels: bar_in takes one bar a beat (left column, top row, length,
// thickness); byte_out gives one framebuffer byte write a beat (page,
// column, byte, last_write flag on the bar's final write).
// Per column it writes the clear above, the bar pages top down, then the
// clear below; columns run left to right, at most 64 writes a bar.
// The first write of a bar passes through the queue, the sequencer's
// command register and the byte_out output register.
// Throughput: one write per cycle while byte_out is not stalled; a bar
// occupies the sequencer for a load step plus one step per write; the next
// bar loads after the last write is issued. The write sequencer sets this rate.
// A 2-entry queue lets bars be taken while the sequencer is busy; bars
// that draw nothing are taken and dropped at once.
// Reset empties the queue and output register; no framebuffer state.
// When the receiver stalls, the current write holds on byte_out and the
// sequencer waits; bar_in backs up once the queue is full.
// Depends on pbvb_pkg, the channel interfaces, pbvb_front, pbvb_fifo, pbvb_back.
`default_nettype none

module page_buffer_vertical_bar_draw
    import pbvb_pkg::*;
#(
    parameter int PAGE_COUNT   = PAGE_COUNT_DEF,
    parameter int COLUMN_COUNT = COLUMN_COUNT_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    pbvb_bar_if.sink     bar_in,
    pbvb_write_if.source byte_out
);

    bar_cmd_t push_cmd;
    bar_cmd_t head_cmd;
    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;

    pbvb_front #(
        .PAGE_COUNT   (PAGE_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_front (
        .rst_n  (rst_n),
        .bar_in (bar_in),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (push_cmd)
    );

    pbvb_fifo #(
        .WIDTH ($bits(bar_cmd_t)),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (head_cmd),
        .empty     (q_empty)
    );

    pbvb_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_cmd   (head_cmd),
        .q_pop   (q_pop),
        .wr_out  (byte_out)
    );

endmodule

`default_nettype wire

@@ rtl/core/pbvb_front.sv @@
// Front end: accepts bars, clips them to the framebuffer and decodes them.
// Depends on pbvb_pkg and pbvb_bar_if; pushes commands into the queue.
`default_nettype none

module pbvb_front
    import pbvb_pkg::*;
#(
    parameter int PAGE_COUNT   = PAGE_COUNT_DEF,
    parameter int COLUMN_COUNT = COLUMN_COUNT_DEF
) (
    input  wire logic   rst_n,
    pbvb_bar_if.sink    bar_in,
    input  wire logic   q_full,
    output logic        q_push,
    output bar_cmd_t    q_cmd
);

    localparam logic [4:0] PC5 = 5'(PAGE_COUNT);
    localparam logic [8:0] CC9 = 9'(COLUMN_COUNT);

    logic [7:0] end_row;
    logic [4:0] fp5;
    logic [4:0] ep5;
    logic [4:0] last_bar;
    logic       on_screen;
    logic       has_above;
    logic       has_below;
    logic [4:0] bar_count;
    logic [4:0] per_col;
    logic [3:0] thick_c;
    logic [8:0] left9;
    logic [8:0] room;
    logic [3:0] cols;
    logic       draws;

    // Classification is purely combinational; nothing held across cycles
    assign bar_in.ready = !q_full && rst_n;

    always_comb
    begin
        end_row   = 8'({2'b00, bar_in.top_row} + {1'b0, bar_in.bar_length} - 8'd1);
        fp5       = {2'b00, bar_in.top_row[5:3]};
        ep5       = end_row[7:3];
        on_screen = fp5 < PC5;
        has_above = (fp5 != 5'd0) && ((fp5 - 5'd1) < PC5);
        has_below = on_screen && (({1'b0, ep5} + 6'd1) < {1'b0, PC5});
        last_bar  = (ep5 < PC5) ? ep5 : 5'(PC5 - 5'd1);
        bar_count = on_screen ? 5'(last_bar - fp5 + 5'd1) : 5'd0;
        per_col   = 5'(bar_count + {4'd0, has_above} + {4'd0, has_below});

        // Thickness clamp and right-edge clip
        thick_c = (bar_in.bar_thickness > 4'(MAX_THICKNESS)) ? 4'(MAX_THICKNESS)
                                                             : bar_in.bar_thickness;
        left9   = {2'b00, bar_in.left_column};
        room    = CC9 - left9;
        if (left9 >= CC9)
            cols = 4'd0;
        else if (room < {5'd0, thick_c})
            cols = room[3:0];
        else
            cols = thick_c;

        draws = (bar_in.bar_length != 7'd0) && (per_col != 5'd0) && (cols != 4'd0);

        q_cmd.left_column = bar_in.left_column;
        q_cmd.first_page  = bar_in.top_row[5:3];
        q_cmd.first_bit   = bar_in.top_row[2:0];
        q_cmd.end_page    = ep5;
        q_cmd.end_bit     = end_row[2:0];
        q_cmd.has_above   = has_above;
        q_cmd.bar_count   = bar_count;
        q_cmd.per_col     = per_col;
        q_cmd.col_count   = cols;
    end

    // Bars that draw nothing are taken and dropped here
    assign q_push = bar_in.valid && bar_in.ready && draws;

endmodule

`default_nettype wire

@@ rtl/core/pbvb_fifo.sv @@
// Small register queue between the front end and the write sequencer.
// Standalone; width and depth are parameters.
`default_nettype none

module pbvb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    // Pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_reg + 1'b1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_reg + 1'b1);
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = (AW+1)'(count_reg + 1'b1);
        else if (do_pop && !do_push)
            count_next = (AW+1)'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

@@ rtl/core/pbvb_back.sv @@
// Back end: walks columns and pages of a decoded bar, one byte write a beat.
// Depends on pbvb_pkg and pbvb_write_if; pops commands from the queue.
`default_nettype none

module pbvb_back
    import pbvb_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    q_empty,
    input  bar_cmd_t     q_cmd,
    output logic         q_pop,
    pbvb_write_if.source wr_out
);

    typedef enum logic [0:0] {ST_IDLE, ST_RUN} state_t;

    state_t            state_reg, state_next;
    bar_cmd_t          cmd_reg, cmd_next;
    logic [2:0]        col_reg, col_next;
    logic [4:0]        step_reg, step_next;
    logic [WCNT_W-1:0] wcnt_reg, wcnt_next;

    logic              out_valid_reg, out_valid_next;
    logic [2:0]        page_reg, page_next;
    logic [6:0]        column_reg, column_next;
    logic [7:0]        byte_reg, byte_next;
    logic              last_reg, last_next;

    logic              slot_free;
    logic              fire;
    logic [4:0]        fp5;
    logic [4:0]        bar_j;
    logic [4:0]        page;
    logic [7:0]        mask;
    logic              col_done;
    logic              is_last;
    logic [7:0]        col_sum;

    assign slot_free = !out_valid_reg || wr_out.ready;
    assign fire      = (state_reg == ST_RUN) && slot_free;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;

    // Page and byte of the current step
    always_comb
    begin
        fp5   = {2'b00, cmd_reg.first_page};
        bar_j = 5'(step_reg - {4'd0, cmd_reg.has_above});
        mask  = 8'h00;
        if (cmd_reg.has_above && step_reg == 5'd0)
            page = 5'(fp5 - 5'd1);
        else if (bar_j < cmd_reg.bar_count)
        begin
            page = 5'(fp5 + bar_j);
            mask = 8'hFF;
            if (page == fp5)
                mask = mask & 8'(8'hFF << cmd_reg.first_bit);
            if (page == cmd_reg.end_page)
                mask = mask & 8'(8'hFF >> (3'd7 - cmd_reg.end_bit));
        end
        else
            page = 5'(fp5 + cmd_reg.bar_count);

        col_done = (step_reg == 5'(cmd_reg.per_col - 5'd1));
        is_last  = (wcnt_reg == WCNT_W'(MAX_WRITES - 1)) ||
                   (col_done && ({1'b0, col_reg} == 4'(cmd_reg.col_count - 4'd1)));
        col_sum  = {1'b0, cmd_reg.left_column} + {5'd0, col_reg};
    end

    // Sequencer and output register
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        col_next       = col_reg;
        step_next      = step_reg;
        wcnt_next      = wcnt_reg;
        out_valid_next = out_valid_reg && !wr_out.ready;
        page_next      = page_reg;
        column_next    = column_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    cmd_next   = q_cmd;
                    col_next   = 3'd0;
                    step_next  = 5'd0;
                    wcnt_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (fire)
                begin
                    out_valid_next = 1'b1;
                    page_next      = page[2:0];
                    column_next    = col_sum[6:0];
                    byte_next      = mask;
                    last_next      = is_last;
                    wcnt_next      = WCNT_W'(wcnt_reg + 1'b1);
                    if (is_last)
                        state_next = ST_IDLE;
                    else if (col_done)
                    begin
                        step_next = 5'd0;
                        col_next  = 3'(col_reg + 3'd1);
                    end
                    else
                        step_next = 5'(step_reg + 5'd1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, walk counters and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cmd_reg       <= '0;
            col_reg       <= '0;
            step_reg      <= '0;
            wcnt_reg      <= '0;
            page_reg      <= '0;
            column_reg    <= '0;
            byte_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cmd_reg       <= cmd_next;
            col_reg       <= col_next;
            step_reg      <= step_next;
            wcnt_reg      <= wcnt_next;
            page_reg      <= page_next;
            column_reg    <= column_next;
            byte_reg      <= byte_next;
            last_reg      <= last_next;
        end
    end

    assign wr_out.valid        = out_valid_reg;
    assign wr_out.page_index   = page_reg;
    assign wr_out.column_index = column_reg;
    assign wr_out.pixel_byte   = byte_reg;
    assign wr_out.last_write   = last_reg;

endmodule

`default_nettype wire

@@ tb/page_buffer_vertical_bar_draw_tb.sv @@
// Testbench for page_buffer_vertical_bar_draw: directed and random bars, with the
// expected framebuffer byte writes computed per accepted beat and checked in order.
// Depends on pbvb_pkg, pbvb_bar_if, pbvb_write_if and the RTL of the block.
`default_nettype none

module page_buffer_vertical_bar_draw_tb;
    import pbvb_pkg::*;

    localparam int PAGE_COUNT   = PAGE_COUNT_DEF;
    localparam int COLUMN_COUNT = COLUMN_COUNT_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int IDLE_PCT     = 9;

    typedef struct {
        logic [6:0] left_column;
        logic [5:0] top_row;
        logic [6:0] bar_length;
        logic [3:0] bar_thickness;
    } bar_t;

    typedef struct {
        logic [2:0] page_index;
        logic [6:0] column_index;
        logic [7:0] pixel_byte;
        logic       last_write;
    } byte_write_t;

    logic clk;
    logic rst_n;

    pbvb_bar_if   bar_in ();
    pbvb_write_if byte_out ();

    page_buffer_vertical_bar_draw #(
        .PAGE_COUNT   (PAGE_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .bar_in   (bar_in),
        .byte_out (byte_out)
    );

    byte_write_t pending_writes[$];
    int          error_count    = 0;
    int          bars_sent      = 0;
    int          blank_bars     = 0;
    int          writes_checked = 0;
    int          cycle_count    = 0;
    bit          gaps_on        = 1'b0;
    bit          stalls_on      = 1'b0;

    // Clock, period 4
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d writes still expected",
                     cycle_count, pending_writes.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Expected writes for one bar: per column, clear above, bar pages, clear below
    function automatic void queue_bar_writes(input bar_t b);
        byte_write_t wr[$];
        int          cols;
        int          col;
        int          page;
        int          bit_pos;
        int          remain;
        int          room;
        logic [7:0]  mask;
        bit          wrote;
        cols = (b.bar_thickness > MAX_THICKNESS) ? MAX_THICKNESS : int'(b.bar_thickness);
        if (b.bar_length == 0)
            cols = 0;
        for (int i = 0; i < cols; i++)
        begin
            col     = int'(b.left_column) + i;
            page    = int'(b.top_row) / PAGE_HEIGHT;
            bit_pos = int'(b.top_row) % PAGE_HEIGHT;
            remain  = int'(b.bar_length);
            wrote   = 1'b0;
            if (col >= COLUMN_COUNT)
                break;
            if (page > 0 && page - 1 < PAGE_COUNT && wr.size() < MAX_WRITES)
                wr.push_back('{3'(page - 1), 7'(col), 8'h00, 1'b0});
            while (page < PAGE_COUNT && remain > 0)
            begin
                room = PAGE_HEIGHT - bit_pos;
                mask = 8'hFF << bit_pos;
                if (room > remain)
                begin
                    mask   = mask & (8'hFF >> (room - remain));
                    remain = 0;
                end
                else
                    remain = remain - room;
                if (wr.size() < MAX_WRITES)
                    wr.push_back('{3'(page), 7'(col), mask, 1'b0});
                wrote   = 1'b1;
                page    = page + 1;
                bit_pos = 0;
            end
            // clear below only when the bar ended inside the framebuffer
            if (wrote && page < PAGE_COUNT && wr.size() < MAX_WRITES)
                wr.push_back('{3'(page), 7'(col), 8'h00, 1'b0});
        end
        if (wr.size() == 0)
            blank_bars++;
        else
            wr[wr.size() - 1].last_write = 1'b1;
        foreach (wr[k])
            pending_writes.push_back(wr[k]);
    endfunction

    // Send one bar beat; caller sits just after a rising edge
    task automatic send_bar(input bar_t b);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(99) < IDLE_PCT)
            gap = $urandom_range(4, 1);
        if (gap > 0)
        begin
            bar_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        bar_in.valid         <= 1'b1;
        bar_in.left_column   <= b.left_column;
        bar_in.top_row       <= b.top_row;
        bar_in.bar_length    <= b.bar_length;
        bar_in.bar_thickness <= b.bar_thickness;
        do
            @(posedge clk);
        while (!bar_in.ready);
        bars_sent++;
        queue_bar_writes(b);
    endtask

    // Receiver: random stalls when enabled, and every write beat checked against the oldest expected
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_out.ready <= 1'b0;
        else
        begin
            if (byte_out.valid && byte_out.ready)
            begin
                if (pending_writes.size() == 0)
                begin
                    $error("unexpected write: page %0d column %0d byte %02h last %0b",
                           byte_out.page_index, byte_out.column_index,
                           byte_out.pixel_byte, byte_out.last_write);
                    error_count++;
                end
                else
                begin
                    byte_write_t exp_wr;
                    exp_wr = pending_writes.pop_front();
                    writes_checked++;
                    if (byte_out.page_index !== exp_wr.page_index)
                    begin
                        $error("page_index: expected %0d, got %0d",
                               exp_wr.page_index, byte_out.page_index);
                        error_count++;
                    end
                    if (byte_out.column_index !== exp_wr.column_index)
                    begin
                        $error("column_index: expected %0d, got %0d",
                               exp_wr.column_index, byte_out.column_index);
                        error_count++;
                    end
                    if (byte_out.pixel_byte !== exp_wr.pixel_byte)
                    begin
                        $error("pixel_byte: expected %02h, got %02h",
                               exp_wr.pixel_byte, byte_out.pixel_byte);
                        error_count++;
                    end
                    if (byte_out.last_write !== exp_wr.last_write)
                    begin
                        $error("last_write: expected %0b, got %0b",
                               exp_wr.last_write, byte_out.last_write);
                        error_count++;
                    end
                end
            end
            byte_out.ready <= stalls_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
        end
    end

    // Mostly well-formed bars, some short, some near the right edge; rest full-range noise
    function automatic bar_t random_bar();
        bar_t b;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 85)
        begin
            b.left_column   = (pick < 10) ? 7'($urandom_range(127, 120))
                                          : 7'($urandom_range(127));
            b.top_row       = ($urandom_range(3) == 0) ? 6'($urandom_range(7) * 8)
                                                       : 6'($urandom_range(63));
            b.bar_length    = $urandom_range(1) ? 7'($urandom_range(16, 1))
                                                : 7'($urandom_range(64, 1));
            b.bar_thickness = ($urandom_range(4) == 0) ? 4'($urandom_range(8, 5))
                                                       : 4'($urandom_range(4, 1));
        end
        else
        begin
            b.left_column   = 7'($urandom);
            b.top_row       = 6'($urandom);
            b.bar_length    = 7'($urandom);
            b.bar_thickness = 4'($urandom);
        end
        return b;
    endfunction

    // Field extremes and each special case, in a fixed order
    task automatic test_corner_bars();
        send_bar('{7'd0,   6'd0,  7'd64,  4'd1});   // full height, page aligned
        send_bar('{7'd0,   6'd0,  7'd0,   4'd0});   // all fields zero
        send_bar('{7'd10,  6'd63, 7'd1,   4'd1});   // last pixel row
        send_bar('{7'd20,  6'd7,  7'd2,   4'd2});   // crosses a page boundary
        send_bar('{7'd30,  6'd8,  7'd8,   4'd1});   // one page, clears above and below
        send_bar('{7'd31,  6'd5,  7'd3,   4'd1});   // inside one page
        send_bar('{7'd40,  6'd12, 7'd0,   4'd3});   // zero length
        send_bar('{7'd41,  6'd12, 7'd5,   4'd0});   // zero thickness
        send_bar('{7'd50,  6'd56, 7'd64,  4'd2});   // runs past the last page
        send_bar('{7'd60,  6'd33, 7'd127, 4'd1});   // length beyond the screen
        send_bar('{7'd70,  6'd1,  7'd62,  4'd15});  // oversized thickness
        send_bar('{7'd80,  6'd9,  7'd20,  4'd9});   // just above max thickness
        send_bar('{7'd127, 6'd63, 7'd127, 4'd15});  // all fields all ones
        send_bar('{7'd127, 6'd20, 7'd4,   4'd8});   // only one column on screen
        send_bar('{7'd124, 6'd14, 7'd30,  4'd6});   // clipped at the right edge
        send_bar('{7'd90,  6'd15, 7'd1,   4'd1});   // single pixel at bit 7
        send_bar('{7'd0,   6'd8,  7'd56,  4'd8});   // widest bar: 64 writes
        send_bar('{7'd100, 6'd48, 7'd9,   4'd3});   // ends on last page with spill
    endtask

    task automatic test_random_bars(input int count);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        repeat (count)
            send_bar(random_bar());
    endtask

    // Back-to-back bars with the receiver always ready
    task automatic test_steady_stream(input int count);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        repeat (count)
            send_bar(random_bar());
    endtask

    initial
    begin
        rst_n                <= 1'b0;
        bar_in.valid         <= 1'b0;
        bar_in.left_column   <= '0;
        bar_in.top_row       <= '0;
        bar_in.bar_length    <= '0;
        bar_in.bar_thickness <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_bars();
        test_random_bars(170);
        test_steady_stream(90);
        test_random_bars(70);
        bar_in.valid <= 1'b0;

        // drain, then watch for stray writes
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bars (%0d drawing nothing), checked %0d byte writes",
                 bars_sent, blank_bars, writes_checked);
        $display("Included clipped columns, bars past the last page, zero and oversized sizes");
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/pbvb_pkg.sv
rtl/core/pbvb_channel_if.sv
rtl/core/pbvb_front.sv
rtl/core/pbvb_fifo.sv
rtl/core/pbvb_back.sv
rtl/core/page_buffer_vertical_bar_draw.sv
tb/page_buffer_vertical_bar_draw_tb.sv
